/* hw/rtl/lbcc_pkg.sv */
// Package for the block cache controller: request and status codes,
// the controller-to-datapath command set and the datapath status bundle.
// No dependencies.
package lbcc_pkg;

    localparam int POS_W           = 40;
    localparam int SLOT_W          = 4;
    localparam int REQ_W           = 2;
    localparam int STATUS_W        = 2;
    localparam int MAX_RESULTS     = 16;
    localparam int CNT_W           = $clog2(MAX_RESULTS);
    localparam int DEF_NUM_SLOTS   = 16;
    localparam int DEF_BLOCK_BYTES = 512;

    localparam logic [REQ_W-1:0] REQ_GET     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_WAIT    = 2'd3;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_EVAL,
        CMD_GET,
        CMD_RELEASE,
        CMD_INVALID,
        CMD_FLUSH_START,
        CMD_FLUSH_STEP
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             flush_last;
    } dp_stat_t;

endpackage

/* hw/rtl/lbcc_datapath.sv */
// Datapath of the block cache controller: slot tags, flags, recency ranks,
// tag match, victim choice, flush sweep and the result registers.
// Depends on lbcc_pkg.
module lbcc_datapath #(
    parameter int NUM_SLOTS   = lbcc_pkg::DEF_NUM_SLOTS,
    parameter int BLOCK_BYTES = lbcc_pkg::DEF_BLOCK_BYTES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lbcc_pkg::cmd_t                      cmd,
    output lbcc_pkg::dp_stat_t                  stat,
    input  logic [lbcc_pkg::REQ_W-1:0]          req_type,
    input  logic [lbcc_pkg::POS_W-1:0]          byte_position,
    input  logic [lbcc_pkg::SLOT_W-1:0]         release_slot,
    input  logic                                was_written,
    output logic                                strobe,
    output logic [lbcc_pkg::STATUS_W-1:0]       status,
    output logic                                hit,
    output logic [lbcc_pkg::SLOT_W-1:0]         slot,
    output logic                                write_back,
    output logic [lbcc_pkg::POS_W-1:0]          write_back_position,
    output logic                                fetch,
    output logic                                last
);
    import lbcc_pkg::*;

    localparam int RW = $clog2(NUM_SLOTS);
    localparam int BO = $clog2(BLOCK_BYTES);
    localparam int TW = POS_W - BO;

    typedef logic [NUM_SLOTS-1:0] vec_t;
    typedef logic [RW-1:0]        rank_t;

    logic [TW-1:0] tag_reg [NUM_SLOTS];
    logic [TW-1:0] tag_next [NUM_SLOTS];
    rank_t rank_reg [NUM_SLOTS];
    rank_t rank_next [NUM_SLOTS];
    vec_t valid_reg, valid_next, dirty_reg, dirty_next, pinned_reg, pinned_next;
    vec_t hitv_reg, hitv_next, vict_reg, vict_next, rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [REQ_W-1:0] req_reg, req_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    logic written_reg, written_next;

    logic strobe_reg, strobe_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic hit_reg, hit_next, wb_reg, wb_next, fetch_reg, fetch_next, last_reg, last_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [POS_W-1:0] wbp_reg, wbp_next;

    vec_t match, vict, hit_first, fsel, gsel;
    logic seen, flush_last;
    rank_t old_rank;
    logic [TW-1:0] sel_tag;
    logic [SLOT_W-1:0] sel_slot;
    logic sel_valid, sel_dirty, sel_pinned;

    always_comb
    begin
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            match[j] = valid_reg[j] && (tag_reg[j] == pos_reg[POS_W-1:BO]);
            vict[j]  = !pinned_reg[j];
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                if (k != j && !pinned_reg[k] && rank_reg[k] > rank_reg[j])
                begin
                    vict[j] = 1'b0;
                end
            end
            // Flush visits the remaining slot of lowest rank first.
            fsel[j] = rem_reg[j];
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                if (rem_reg[k] && rank_reg[k] < rank_reg[j])
                begin
                    fsel[j] = 1'b0;
                end
            end
        end
        seen = 1'b0;
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            hit_first[j] = hitv_reg[j] && !seen;
            seen = seen | hitv_reg[j];
        end
    end

    assign flush_last = ((rem_reg & ~fsel) == '0) || (cnt_reg == CNT_W'(MAX_RESULTS - 1));
    assign stat.req = req_reg;
    assign stat.flush_last = flush_last;

    // One-hot selection of the slot a get or a flush step works on.
    always_comb
    begin
        if (cmd == CMD_FLUSH_STEP)
        begin
            gsel = fsel;
        end
        else if (hitv_reg != '0)
        begin
            gsel = hit_first;
        end
        else
        begin
            gsel = vict_reg;
        end
        sel_tag = '0;
        sel_slot = '0;
        old_rank = '0;
        sel_valid = 1'b0;
        sel_dirty = 1'b0;
        sel_pinned = 1'b0;
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            if (gsel[j])
            begin
                sel_tag = sel_tag | tag_reg[j];
                sel_slot = sel_slot | SLOT_W'(j);
                old_rank = old_rank | rank_reg[j];
                sel_valid = sel_valid | valid_reg[j];
                sel_dirty = sel_dirty | dirty_reg[j];
                sel_pinned = sel_pinned | pinned_reg[j];
            end
        end
    end

    always_comb
    begin
        tag_next = tag_reg;
        rank_next = rank_reg;
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        pinned_next = pinned_reg;
        hitv_next = hitv_reg;
        vict_next = vict_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        req_next = req_reg;
        pos_next = pos_reg;
        rslot_next = rslot_reg;
        written_next = written_reg;
        strobe_next = 1'b0;
        status_next = status_reg;
        hit_next = hit_reg;
        slot_next = slot_reg;
        wb_next = wb_reg;
        wbp_next = wbp_reg;
        fetch_next = fetch_reg;
        last_next = last_reg;
        if (cmd == CMD_GET || cmd == CMD_RELEASE || cmd == CMD_INVALID
            || cmd == CMD_FLUSH_STEP)
        begin
            strobe_next = 1'b1;
            status_next = ST_OK;
            hit_next = 1'b0;
            slot_next = '0;
            wb_next = 1'b0;
            wbp_next = '0;
            fetch_next = 1'b0;
            last_next = 1'b1;
        end
        unique case (cmd)
            CMD_NONE:
            begin
            end
            CMD_LOAD:
            begin
                req_next = req_type;
                pos_next = byte_position;
                rslot_next = release_slot;
                written_next = was_written;
            end
            CMD_EVAL:
            begin
                hitv_next = match;
                vict_next = vict;
            end
            CMD_GET:
            begin
                if (pos_reg[BO-1:0] != '0)
                begin
                    status_next = ST_INVALID;
                end
                else if (hitv_reg != '0 && sel_pinned)
                begin
                    status_next = ST_WAIT;
                    hit_next = 1'b1;
                    slot_next = sel_slot;
                end
                else if (hitv_reg == '0 && vict_reg == '0)
                begin
                    status_next = ST_BUSY;
                end
                else
                begin
                    slot_next = sel_slot;
                    hit_next = (hitv_reg != '0);
                    if (hitv_reg == '0)
                    begin
                        fetch_next = 1'b1;
                        wb_next = sel_valid && sel_dirty;
                        if (sel_valid && sel_dirty)
                        begin
                            wbp_next = {sel_tag, {BO{1'b0}}};
                        end
                    end
                    for (int j = 0; j < NUM_SLOTS; j++)
                    begin
                        if (gsel[j])
                        begin
                            pinned_next[j] = 1'b1;
                            rank_next[j] = '0;
                            if (hitv_reg == '0)
                            begin
                                tag_next[j] = pos_reg[POS_W-1:BO];
                                valid_next[j] = 1'b1;
                                dirty_next[j] = 1'b0;
                            end
                        end
                        else if (rank_reg[j] < old_rank)
                        begin
                            rank_next[j] = rank_reg[j] + 1'b1;
                        end
                    end
                end
            end
            CMD_RELEASE:
            begin
                slot_next = rslot_reg;
                for (int j = 0; j < NUM_SLOTS; j++)
                begin
                    if (32'(rslot_reg) == j)
                    begin
                        pinned_next[j] = 1'b0;
                        dirty_next[j] = dirty_reg[j] | written_reg;
                    end
                end
            end
            CMD_INVALID:
            begin
                status_next = ST_INVALID;
            end
            CMD_FLUSH_START:
            begin
                rem_next = valid_reg & dirty_reg & ~pinned_reg;
                cnt_next = '0;
            end
            CMD_FLUSH_STEP:
            begin
                if (rem_reg != '0)
                begin
                    slot_next = sel_slot;
                    wb_next = 1'b1;
                    wbp_next = {sel_tag, {BO{1'b0}}};
                    last_next = flush_last;
                    dirty_next = dirty_reg & ~fsel;
                    rem_next = rem_reg & ~fsel;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            pinned_reg <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
            strobe_reg <= 1'b0;
            for (int j = 0; j < NUM_SLOTS; j++)
            begin
                rank_reg[j] <= RW'(j);
            end
        end
        else
        begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            pinned_reg <= pinned_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_next;
            strobe_reg <= strobe_next;
            rank_reg <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        hitv_reg <= hitv_next;
        vict_reg <= vict_next;
        req_reg <= req_next;
        pos_reg <= pos_next;
        rslot_reg <= rslot_next;
        written_reg <= written_next;
        status_reg <= status_next;
        hit_reg <= hit_next;
        slot_reg <= slot_next;
        wb_reg <= wb_next;
        wbp_reg <= wbp_next;
        fetch_reg <= fetch_next;
        last_reg <= last_next;
    end

    assign strobe = strobe_reg;
    assign status = status_reg;
    assign hit = hit_reg;
    assign slot = slot_reg;
    assign write_back = wb_reg;
    assign write_back_position = wbp_reg;
    assign fetch = fetch_reg;
    assign last = last_reg;

endmodule

/* hw/rtl/lbcc_controller.sv */
// Sequencing state machine of the block cache controller.
// Depends on lbcc_pkg.
module lbcc_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  lbcc_pkg::dp_stat_t stat,
    output lbcc_pkg::cmd_t     cmd
);
    import lbcc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_ACT, S_FLUSH} state_t;

    state_t state_reg;
    logic busy_reg;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  cmd = start ? CMD_LOAD : CMD_NONE;
            S_EVAL:  cmd = (stat.req == REQ_FLUSH) ? CMD_FLUSH_START : CMD_EVAL;
            S_ACT:
            begin
                if (stat.req == REQ_GET)
                begin
                    cmd = CMD_GET;
                end
                else if (stat.req == REQ_RELEASE)
                begin
                    cmd = CMD_RELEASE;
                end
                else
                begin
                    cmd = CMD_INVALID;
                end
            end
            S_FLUSH: cmd = CMD_FLUSH_STEP;
            default: cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_EVAL;
                        busy_reg <= 1'b1;
                    end
                end
                S_EVAL:
                begin
                    state_reg <= (stat.req == REQ_FLUSH) ? S_FLUSH : S_ACT;
                end
                S_ACT:
                begin
                    state_reg <= S_IDLE;
                    busy_reg <= 1'b0;
                end
                S_FLUSH:
                begin
                    if (stat.flush_last)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;

endmodule

/* hw/rtl/lru_block_cache_controller_core.sv */
// Get, release and unknown requests: busy in the evaluate and act states, then one
// word on the result ports, registered from act; a new request may be started in
// the cycle of that word. Flush: busy in evaluate and the sweep, one word per cycle
// for each dirty unpinned slot (at most 16, at least one word); busy drops in the
// cycle of the last word. The receiver cannot stall, so no word is ever held.
// Reset (rst_n low, asynchronous) empties every slot and restores rank order.
module lru_block_cache_controller_core #(
    parameter int NUM_SLOTS   = lbcc_pkg::DEF_NUM_SLOTS,
    parameter int BLOCK_BYTES = lbcc_pkg::DEF_BLOCK_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lbcc_pkg::REQ_W-1:0]    req_type,
    input  logic [lbcc_pkg::POS_W-1:0]    byte_position,
    input  logic [lbcc_pkg::SLOT_W-1:0]   release_slot,
    input  logic                          was_written,
    output logic                          strobe,
    output logic [lbcc_pkg::STATUS_W-1:0] status,
    output logic                          hit,
    output logic [lbcc_pkg::SLOT_W-1:0]   slot,
    output logic                          write_back,
    output logic [lbcc_pkg::POS_W-1:0]    write_back_position,
    output logic                          fetch,
    output logic                          last
);
    import lbcc_pkg::*;

    // The controller steps through load, evaluate and act (or the flush
    // sweep); the datapath owns all slot state and the result registers.
    // The tag match and victim search are one parallel comparison stage;
    // the flush sweep emits one slot a cycle.
    cmd_t cmd;
    dp_stat_t stat;

    lbcc_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    lbcc_datapath #(
        .NUM_SLOTS   (NUM_SLOTS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .req_type            (req_type),
        .byte_position       (byte_position),
        .release_slot        (release_slot),
        .was_written         (was_written),
        .strobe              (strobe),
        .status              (status),
        .hit                 (hit),
        .slot                (slot),
        .write_back          (write_back),
        .write_back_position (write_back_position),
        .fetch               (fetch),
        .last                (last)
    );

endmodule
